>>> rtl/atup_pkg.sv
// ----------------------------------------------------------------------------
// atup_pkg: shared types and constants for the ASCII-to-unsigned parser
// Character codes, parse phase codes, result status codes, the digit
// decoder and the control group passed from the converter to the output stage.
// ----------------------------------------------------------------------------
package atup_pkg;

  // Result status codes
  typedef logic [1:0] status_t;
  localparam status_t STAT_OK       = 2'd0;
  localparam status_t STAT_INVALID  = 2'd1;
  localparam status_t STAT_OVERFLOW = 2'd2;

  // Parse phase codes
  typedef logic [1:0] phase_t;
  localparam phase_t PH_SKIP   = 2'd0;
  localparam phase_t PH_ZERO   = 2'd1;
  localparam phase_t PH_DIGITS = 2'd2;

  // Character codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HIGH   = 8'h80;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_UA     = 8'h41;
  localparam logic [7:0] CH_UZ     = 8'h5A;
  localparam logic [7:0] CH_LA     = 8'h61;
  localparam logic [7:0] CH_LZ     = 8'h7A;
  localparam logic [7:0] CH_UX     = 8'h58;
  localparam logic [7:0] CASE_MASK = 8'hDF;

  // Radix constants
  typedef logic [5:0] base_t;
  localparam base_t BASE_AUTO = 6'd0;
  localparam base_t BASE_OCT  = 6'd8;
  localparam base_t BASE_DEC  = 6'd10;
  localparam base_t BASE_HEX  = 6'd16;

  // Digit value of a non-alphanumeric byte
  typedef logic [6:0] digit_t;
  localparam digit_t DIGIT_NONE = 7'd64;

  // Control group from the converter to the output register
  typedef struct packed {
    logic    emit;
    status_t status;
  } res_ctl_t;

  // Decode a byte into its digit value (0..35), or DIGIT_NONE
  function automatic digit_t digit_of(input logic [7:0] ch);
    logic [7:0] d;
    begin
      d = 8'(DIGIT_NONE);
      if (ch inside {[CH_0:CH_9]}) begin
        d = ch - CH_0;
      end else if (ch inside {[CH_UA:CH_UZ]}) begin
        d = ch - (CH_UA - 8'd10);
      end else if (ch inside {[CH_LA:CH_LZ]}) begin
        d = ch - (CH_LA - 8'd10);
      end
      return d[6:0];
    end
  endfunction

endpackage

>>> rtl/ascii_to_unsigned_parser_unit.sv
// ----------------------------------------------------------------------------
// ascii_to_unsigned_parser_unit: streaming text-to-unsigned converter
// Consumes one character byte per beat and emits one result per number.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one character per beat (valid/ready). Leading blanks and bytes
//           0x80 and above are skipped, a 0x/0X prefix is honored for base 0
//           or 16, and the first non-digit ends the number and is dropped.
//   out_* : one result beat per number: value, status (ok, invalid,
//           overflow) and chars_used (saturating).
//   cfg_* : write of number_base (0 = detect from prefix); cfg_ready is
//           always high. Write only while the block is idle; the base is
//           sampled at the start of each number.
// Timing: the terminating byte passes the input register, and its result is
//   loaded into the result register when the result slot is free. One
//   character is converted per cycle unless the result register stalls,
//   limited by the single multiply-accumulate feeding the value register.
// Stall: the result register holds while out_ready is low; the input
//   register keeps accepting until it holds a byte that cannot advance.
// Reset: synchronous active-low rst_n clears both valid flags, the
//   conversion state and the base register (base 0).
// ----------------------------------------------------------------------------
module ascii_to_unsigned_parser_unit #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [7:0]             in_char_in,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [VALUE_WIDTH-1:0] out_value,
  output atup_pkg::status_t      out_status,
  output logic [COUNT_WIDTH-1:0] out_chars_used,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  atup_pkg::base_t        cfg_number_base
);
  import atup_pkg::*;

  logic                   q_valid;
  logic [7:0]             q_char;
  logic                   fire;
  base_t                  base_cfg_r;
  res_ctl_t               res_ctl;
  logic [VALUE_WIDTH-1:0] res_value;
  logic [COUNT_WIDTH-1:0] res_count;

  // Hold the base register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_cfg_r <= BASE_AUTO;
    end else if (cfg_valid && cfg_ready) begin
      base_cfg_r <= cfg_number_base;
    end
  end

  // Advance a character when the result slot is free or being emptied
  assign fire = q_valid && (!out_valid || out_ready);

  atup_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_char_in (in_char_in),
    .advance    (fire),
    .q_valid    (q_valid),
    .q_char     (q_char)
  );

  atup_conv_core #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .ch        (q_char),
    .cfg_base  (base_cfg_r),
    .res_ctl   (res_ctl),
    .res_value (res_value),
    .res_count (res_count)
  );

  atup_out_reg #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (fire && res_ctl.emit),
    .res_ctl        (res_ctl),
    .res_value      (res_value),
    .res_count      (res_count),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_value      (out_value),
    .out_status     (out_status),
    .out_chars_used (out_chars_used)
  );

endmodule

>>> rtl/atup_in_reg.sv
// ----------------------------------------------------------------------------
// atup_in_reg: input register stage
// Captures one character beat and holds it until the converter takes it.
// ----------------------------------------------------------------------------
module atup_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_char_in,
  input  logic       advance,
  output logic       q_valid,
  output logic [7:0] q_char
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] char_r;
  logic       take;

  // Accept a new beat when empty or when the held beat moves on
  assign in_ready = !valid_r || advance;
  assign take     = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the character payload
  always_ff @(posedge clk) begin
    if (take) begin
      char_r <= in_char_in;
    end
  end

  assign q_valid = valid_r;
  assign q_char  = char_r;

endmodule

>>> rtl/atup_conv_core.sv
// ----------------------------------------------------------------------------
// atup_conv_core: conversion state and single-pass digit step
// Keeps the running conversion and, for each character, skips, detects the
// prefix, multiply-accumulates a digit or finishes with one result.
// ----------------------------------------------------------------------------
module atup_conv_core #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  logic [7:0]             ch,
  input  atup_pkg::base_t        cfg_base,
  output atup_pkg::res_ctl_t     res_ctl,
  output logic [VALUE_WIDTH-1:0] res_value,
  output logic [COUNT_WIDTH-1:0] res_count
);
  import atup_pkg::*;

  localparam int FULL_WIDTH = VALUE_WIDTH + 7;

  phase_t                 phase_r, phase_nxt;
  base_t                  base_r, base_nxt;
  logic [VALUE_WIDTH-1:0] acc_r, acc_nxt;
  logic                   seen_r, seen_nxt;
  logic                   ovf_r, ovf_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;

  base_t                  eb;
  logic [VALUE_WIDTH-1:0] ea;
  logic                   es;
  logic                   eo;
  logic [COUNT_WIDTH-1:0] ec;
  logic                   do_digit;
  logic                   finish;
  digit_t                 dig;
  logic [FULL_WIDTH-1:0]  full;
  logic                   auto_hex;

  // Saturating count increment
  function automatic logic [COUNT_WIDTH-1:0] sat_add(
    input logic [COUNT_WIDTH-1:0] c,
    input logic [1:0]             n
  );
    logic [COUNT_WIDTH:0] s;
    begin
      s = {1'b0, c} + {{(COUNT_WIDTH - 1){1'b0}}, n};
      return s[COUNT_WIDTH] ? {COUNT_WIDTH{1'b1}} : s[COUNT_WIDTH-1:0];
    end
  endfunction

  assign dig      = digit_of(ch);
  assign auto_hex = ((ch & CASE_MASK) == CH_UX) &&
                    ((cfg_base == BASE_AUTO) || (cfg_base == BASE_HEX));
  // Multiply-accumulate with headroom for overflow detection
  assign full = ({7'b0, ea} * {{(VALUE_WIDTH + 1){1'b0}}, eb}) +
                {{VALUE_WIDTH{1'b0}}, dig};

  always_comb begin
    phase_nxt = phase_r;
    base_nxt  = base_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    ovf_nxt   = ovf_r;
    cnt_nxt   = cnt_r;
    eb        = base_r;
    ea        = acc_r;
    es        = seen_r;
    eo        = ovf_r;
    ec        = cnt_r;
    do_digit  = 1'b0;
    finish    = 1'b0;
    res_ctl   = '0;
    res_value = '0;
    res_count = '0;

    // Resolve what this character means in the current phase
    case (phase_r)
      PH_SKIP: begin
        if (ch == CH_NUL) begin
          finish = 1'b1;
        end else if ((ch <= CH_SPACE) || (ch >= CH_HIGH)) begin
          cnt_nxt = sat_add(cnt_r, 2'd1);
        end else if (ch == CH_0) begin
          phase_nxt = PH_ZERO;
        end else begin
          eb       = (cfg_base == BASE_AUTO) ? BASE_DEC : cfg_base;
          ea       = '0;
          es       = 1'b0;
          eo       = 1'b0;
          do_digit = 1'b1;
        end
      end
      PH_ZERO: begin
        if (auto_hex) begin
          phase_nxt = PH_DIGITS;
          base_nxt  = BASE_HEX;
          cnt_nxt   = sat_add(cnt_r, 2'd2);
        end else begin
          // The leading zero counts as a digit of the resolved base
          eb       = (cfg_base == BASE_AUTO) ? BASE_OCT : cfg_base;
          ea       = '0;
          es       = 1'b1;
          eo       = 1'b0;
          ec       = sat_add(cnt_r, 2'd1);
          do_digit = 1'b1;
        end
      end
      default: begin
        do_digit = 1'b1;
      end
    endcase

    // Take a digit below the base, or end the conversion
    if (do_digit) begin
      phase_nxt = PH_DIGITS;
      base_nxt  = eb;
      if (dig < {1'b0, eb}) begin
        acc_nxt  = full[VALUE_WIDTH-1:0];
        ovf_nxt  = eo || (|full[FULL_WIDTH-1:VALUE_WIDTH]);
        seen_nxt = 1'b1;
        cnt_nxt  = sat_add(ec, 2'd1);
      end else begin
        finish = 1'b1;
      end
    end

    // Emit the result and clear for the next conversion
    if (finish) begin
      res_ctl.emit = 1'b1;
      res_count    = ec;
      if (!es) begin
        res_ctl.status = STAT_INVALID;
        res_value      = '0;
      end else if (eo) begin
        res_ctl.status = STAT_OVERFLOW;
        res_value      = {VALUE_WIDTH{1'b1}};
      end else begin
        res_ctl.status = STAT_OK;
        res_value      = ea;
      end
      phase_nxt = PH_SKIP;
      base_nxt  = BASE_AUTO;
      acc_nxt   = '0;
      seen_nxt  = 1'b0;
      ovf_nxt   = 1'b0;
      cnt_nxt   = '0;
    end
  end

  // Advance conversion state once per character
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SKIP;
      base_r  <= BASE_AUTO;
      acc_r   <= '0;
      seen_r  <= 1'b0;
      ovf_r   <= 1'b0;
      cnt_r   <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      ovf_r   <= ovf_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

>>> rtl/atup_out_reg.sv
// ----------------------------------------------------------------------------
// atup_out_reg: result register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module atup_out_reg #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   load,
  input  atup_pkg::res_ctl_t     res_ctl,
  input  logic [VALUE_WIDTH-1:0] res_value,
  input  logic [COUNT_WIDTH-1:0] res_count,
  input  logic                   out_ready,
  output logic                   out_valid,
  output logic [VALUE_WIDTH-1:0] out_value,
  output atup_pkg::status_t      out_status,
  output logic [COUNT_WIDTH-1:0] out_chars_used
);
  import atup_pkg::*;

  logic                   valid_r, valid_nxt;
  logic [VALUE_WIDTH-1:0] value_r;
  status_t                status_r;
  logic [COUNT_WIDTH-1:0] count_r;

  // Set on a new result, drop when the receiver takes it
  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Hold the result payload
  always_ff @(posedge clk) begin
    if (load) begin
      value_r  <= res_value;
      status_r <= res_ctl.status;
      count_r  <= res_count;
    end
  end

  assign out_valid      = valid_r;
  assign out_value      = value_r;
  assign out_status     = status_r;
  assign out_chars_used = count_r;

endmodule

>>> rtl/atup_checker.sv
// ----------------------------------------------------------------------------
// atup_checker: port-level checks for the parser unit
// Watches the result channel for consistent status and value encodings.
// ----------------------------------------------------------------------------
module atup_checker #(
  parameter int VALUE_WIDTH = 32,
  parameter int COUNT_WIDTH = 16
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_value,
  input logic [1:0]             out_status,
  input logic [COUNT_WIDTH-1:0] out_chars_used
);
  import atup_pkg::*;

  // Status is one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STAT_OK || out_status == STAT_INVALID ||
                   out_status == STAT_OVERFLOW))
    else $error("result status code undefined");

  // No digits means a zero value
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_INVALID) |-> (out_value == '0))
    else $error("invalid result with nonzero value");

  // Overflow saturates the value
  a_overflow_ones: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == STAT_OVERFLOW) |-> (&out_value))
    else $error("overflow result not saturated");

  // A stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && out_valid && !out_ready) |=>
      (out_valid && $stable(out_value) && $stable(out_status) &&
       $stable(out_chars_used)))
    else $error("stalled result beat changed");

endmodule

bind ascii_to_unsigned_parser_unit atup_checker #(
  .VALUE_WIDTH (VALUE_WIDTH),
  .COUNT_WIDTH (COUNT_WIDTH)
) u_atup_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_value      (out_value),
  .out_status     (out_status),
  .out_chars_used (out_chars_used)
);
